// File: design/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, key codes and scan code tables for the scan code translator.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int unsigned ScanW = 8;
  localparam int unsigned KeyW  = 9;
  localparam int unsigned ModW  = 3;

  // scan code values
  localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
  localparam logic [6:0] SC_LSHIFT    = 7'h2A;
  localparam logic [6:0] SC_RSHIFT    = 7'h36;
  localparam logic [6:0] SC_CTRL      = 7'h1D;
  localparam logic [6:0] SC_ALT       = 7'h38;
  localparam logic [6:0] SC_CAPS      = 7'h3A;
  localparam logic [6:0] SC_NUM       = 7'h45;
  localparam logic [6:0] SC_F1        = 7'h3B;
  localparam logic [6:0] SC_F10       = 7'h44;
  localparam logic [6:0] SC_F11       = 7'h57;
  localparam logic [6:0] SC_F12       = 7'h58;
  localparam logic [6:0] SC_ENTER     = 7'h1C;
  localparam logic [6:0] SC_SLASH     = 7'h35;

  // key codes
  localparam logic [KeyW-1:0] KEY_NONE  = 9'd0;
  localparam logic [KeyW-1:0] NAV_UP    = 9'd256;
  localparam logic [KeyW-1:0] NAV_DOWN  = 9'd257;
  localparam logic [KeyW-1:0] NAV_LEFT  = 9'd258;
  localparam logic [KeyW-1:0] NAV_RIGHT = 9'd259;
  localparam logic [KeyW-1:0] NAV_HOME  = 9'd260;
  localparam logic [KeyW-1:0] NAV_END   = 9'd261;
  localparam logic [KeyW-1:0] NAV_PAGEUP = 9'd262;
  localparam logic [KeyW-1:0] NAV_PAGEDN = 9'd263;
  localparam logic [KeyW-1:0] NAV_INS   = 9'd264;
  localparam logic [KeyW-1:0] NAV_DEL   = 9'd265;
  localparam logic [KeyW-1:0] KEY_F1    = 9'd266;
  localparam logic [KeyW-1:0] KEY_F11   = 9'd276;
  localparam logic [KeyW-1:0] KEY_F12   = 9'd277;

  // characters used by the decoder
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SLASH   = 8'd47;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;

  // keyboard flags kept between beats
  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
    logic num;
    logic ext;
  } kst_state_t;

  // navigation meaning of a keypad or extended code, zero if none
  function automatic logic [KeyW-1:0] nav_of(input logic [6:0] c);
    logic [KeyW-1:0] k;
    case (c)
      7'h48:   k = NAV_UP;
      7'h50:   k = NAV_DOWN;
      7'h4B:   k = NAV_LEFT;
      7'h4D:   k = NAV_RIGHT;
      7'h47:   k = NAV_HOME;
      7'h4F:   k = NAV_END;
      7'h49:   k = NAV_PAGEUP;
      7'h51:   k = NAV_PAGEDN;
      7'h52:   k = NAV_INS;
      7'h53:   k = NAV_DEL;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  // keypad digit of a navigation code
  function automatic logic [7:0] digit_of(input logic [6:0] c);
    logic [7:0] d;
    case (c)
      7'h48:   d = 8'd56;
      7'h50:   d = 8'd50;
      7'h4B:   d = 8'd52;
      7'h4D:   d = 8'd54;
      7'h47:   d = 8'd55;
      7'h4F:   d = 8'd49;
      7'h49:   d = 8'd57;
      7'h51:   d = 8'd51;
      7'h52:   d = 8'd48;
      default: d = 8'd46;
    endcase
    return d;
  endfunction

  // unshifted character table
  function automatic logic [7:0] low_map(input logic [6:0] c);
    logic [7:0] v;
    case (c)
      7'h01: v = 8'd27;   7'h02: v = 8'd49;   7'h03: v = 8'd50;   7'h04: v = 8'd51;
      7'h05: v = 8'd52;   7'h06: v = 8'd53;   7'h07: v = 8'd54;   7'h08: v = 8'd55;
      7'h09: v = 8'd56;   7'h0A: v = 8'd57;   7'h0B: v = 8'd48;   7'h0C: v = 8'd42;
      7'h0D: v = 8'd45;   7'h0E: v = 8'd8;    7'h0F: v = 8'd9;
      7'h10: v = 8'd113;  7'h11: v = 8'd119;  7'h12: v = 8'd101;  7'h13: v = 8'd114;
      7'h14: v = 8'd116;  7'h15: v = 8'd121;  7'h16: v = 8'd117;  7'h17: v = 8'd133;
      7'h18: v = 8'd111;  7'h19: v = 8'd112;  7'h1A: v = 8'd129;  7'h1B: v = 8'd132;
      7'h1C: v = 8'd10;
      7'h1E: v = 8'd97;   7'h1F: v = 8'd115;  7'h20: v = 8'd100;  7'h21: v = 8'd102;
      7'h22: v = 8'd103;  7'h23: v = 8'd104;  7'h24: v = 8'd106;  7'h25: v = 8'd107;
      7'h26: v = 8'd108;  7'h27: v = 8'd130;  7'h28: v = 8'd105;  7'h29: v = 8'd34;
      7'h2B: v = 8'd44;   7'h56: v = 8'd60;
      7'h2C: v = 8'd122;  7'h2D: v = 8'd120;  7'h2E: v = 8'd99;   7'h2F: v = 8'd118;
      7'h30: v = 8'd98;   7'h31: v = 8'd110;  7'h32: v = 8'd109;  7'h33: v = 8'd131;
      7'h34: v = 8'd128;  7'h35: v = 8'd46;   7'h39: v = 8'd32;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // shifted character table
  function automatic logic [7:0] up_map(input logic [6:0] c);
    logic [7:0] v;
    case (c)
      7'h01: v = 8'd27;   7'h02: v = 8'd33;   7'h03: v = 8'd39;   7'h04: v = 8'd94;
      7'h05: v = 8'd43;   7'h06: v = 8'd37;   7'h07: v = 8'd38;   7'h08: v = 8'd47;
      7'h09: v = 8'd40;   7'h0A: v = 8'd41;   7'h0B: v = 8'd61;   7'h0C: v = 8'd63;
      7'h0D: v = 8'd95;   7'h0E: v = 8'd8;    7'h0F: v = 8'd9;
      7'h10: v = 8'd81;   7'h11: v = 8'd87;   7'h12: v = 8'd69;   7'h13: v = 8'd82;
      7'h14: v = 8'd84;   7'h15: v = 8'd89;   7'h16: v = 8'd85;   7'h17: v = 8'd73;
      7'h18: v = 8'd79;   7'h19: v = 8'd80;   7'h1A: v = 8'd139;  7'h1B: v = 8'd137;
      7'h1C: v = 8'd10;
      7'h1E: v = 8'd65;   7'h1F: v = 8'd83;   7'h20: v = 8'd68;   7'h21: v = 8'd70;
      7'h22: v = 8'd71;   7'h23: v = 8'd72;   7'h24: v = 8'd74;   7'h25: v = 8'd75;
      7'h26: v = 8'd76;   7'h27: v = 8'd136;  7'h28: v = 8'd134;  7'h29: v = 8'd69;
      7'h2B: v = 8'd59;   7'h56: v = 8'd62;
      7'h2C: v = 8'd90;   7'h2D: v = 8'd88;   7'h2E: v = 8'd67;   7'h2F: v = 8'd86;
      7'h30: v = 8'd66;   7'h31: v = 8'd78;   7'h32: v = 8'd77;   7'h33: v = 8'd138;
      7'h34: v = 8'd135;  7'h35: v = 8'd58;   7'h39: v = 8'd32;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: design/kst_if.sv
// ----------------------------------------------------------------------------
// kst_if
// Valid/ready channels for scan bytes in and key events out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kst_in_if;
  logic                     valid;
  logic                     ready;
  logic [kst_pkg::ScanW-1:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface kst_out_if;
  logic                     valid;
  logic                     ready;
  logic [kst_pkg::KeyW-1:0] key_code;
  logic                     pressed;
  logic [kst_pkg::ModW-1:0] modifiers;

  modport source (output valid, output key_code, output pressed, output modifiers,
                  input ready);
  modport sink   (input valid, input key_code, input pressed, input modifiers,
                  output ready);
endinterface

`default_nettype wire

// File: design/kst_decode.sv
// ----------------------------------------------------------------------------
// kst_decode
// Decodes one scan byte against the current flags into a key code and the
// flags that follow it.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_decode (
  input  wire logic [kst_pkg::ScanW-1:0] scan_byte,
  input  wire kst_pkg::kst_state_t       st,
  output logic [kst_pkg::KeyW-1:0]       key_code,
  output kst_pkg::kst_state_t            st_nxt
);
  import kst_pkg::*;

  logic [6:0]      c;
  logic            rel;
  logic [KeyW-1:0] nav;
  logic [7:0]      lo;
  logic [7:0]      ch;
  logic            letter;
  logic            upper;
  logic            ext_hit;

  assign c   = scan_byte[6:0];
  assign rel = scan_byte[7];
  assign nav = nav_of(c);
  assign lo  = low_map(c);

  // character path: caps flips case only for letters, ctrl folds a..z
  always_comb begin
    letter = (lo inside {[CH_LOWER_A:CH_LOWER_Z]}) || (lo inside {[8'd128:8'd133]});
    upper  = st.shift ^ (st.caps & letter);
    ch     = upper ? up_map(c) : lo;
  end

  // prefix, modifiers, locks, then key decode
  always_comb begin
    st_nxt   = st;
    key_code = KEY_NONE;
    ext_hit  = 1'b0;
    if (scan_byte == SC_PREFIX_E0) begin
      st_nxt.ext = 1'b1;
    end else if (c == SC_LSHIFT || c == SC_RSHIFT) begin
      st_nxt.shift = ~rel;
    end else if (c == SC_CTRL) begin
      st_nxt.ctrl = ~rel;
    end else if (c == SC_ALT) begin
      st_nxt.alt = ~rel;
    end else if (!rel && c == SC_CAPS) begin
      st_nxt.caps = ~st.caps;
    end else if (!rel && c == SC_NUM) begin
      st_nxt.num = ~st.num;
    end else begin
      // extended meaning takes priority after a prefix
      if (st.ext) begin
        st_nxt.ext = 1'b0;
        if (nav != KEY_NONE) begin
          key_code = nav;
          ext_hit  = 1'b1;
        end else if (c == SC_ENTER) begin
          key_code = {1'b0, CH_NEWLINE};
          ext_hit  = 1'b1;
        end else if (c == SC_SLASH) begin
          key_code = {1'b0, CH_SLASH};
          ext_hit  = 1'b1;
        end
      end
      if (!ext_hit) begin
        if (nav != KEY_NONE) begin
          key_code = (!st.num && !st.shift) ? nav : {1'b0, digit_of(c)};
        end else if (c inside {[SC_F1:SC_F10]}) begin
          key_code = KEY_F1 + {2'b00, c - SC_F1};
        end else if (c == SC_F11) begin
          key_code = KEY_F11;
        end else if (c == SC_F12) begin
          key_code = KEY_F12;
        end else if (st.ctrl && (ch inside {[CH_LOWER_A:CH_LOWER_Z]})) begin
          key_code = {1'b0, ch - CH_LOWER_A + 8'd1};
        end else begin
          key_code = {1'b0, ch};
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/keyboard_scancode_translator_top.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_translator_top
// Set 1 scan code to key event translator for a Turkish-Q layout.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw scan byte per beat; out_ch returns exactly one
//   event per accepted byte: key code, pressed bit and the shift/ctrl/alt
//   flags as they stood before that byte.
//   A byte is captured in an input register, decoded combinationally against
//   the held flags, and lands in the output register, whose valid flag
//   drives out_ch.valid.
//   Throughput is one byte per cycle: the decode stage advances whenever
//   the output register is empty or being taken, and in_ch.ready stays high
//   while the input register can move on in the same cycle.
//   Flags update as each byte passes the decode stage, so back-to-back bytes
//   see the flags left by the byte before them.
//   When the receiver stalls, one event waits in the output register and
//   one byte in the input register; after that in_ch.ready drops.
//   Synchronous reset clears both registers' valid flags and all keyboard
//   flags (shift, ctrl, alt, caps lock, num lock, prefix).
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scancode_translator_top (
  input wire logic clk,
  input wire logic rst_n,
  kst_in_if.sink   in_ch,
  kst_out_if.source out_ch
);
  import kst_pkg::*;

  logic             in_valid_r;
  logic [ScanW-1:0] in_byte_r;
  kst_state_t       st_r;
  kst_state_t       st_nxt;
  logic             out_valid_r;
  logic [KeyW-1:0]  out_key_r;
  logic             out_pressed_r;
  logic [ModW-1:0]  out_mods_r;
  logic [KeyW-1:0]  dec_key;
  logic             advance;

  // decode stage moves when its result has somewhere to go
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  kst_decode u_decode (
    .scan_byte (in_byte_r),
    .st        (st_r),
    .key_code  (dec_key),
    .st_nxt    (st_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.scan_byte;
    end
  end

  // keyboard flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_key_r     <= dec_key;
      out_pressed_r <= ~in_byte_r[ScanW-1];
      out_mods_r    <= {st_r.alt, st_r.ctrl, st_r.shift};
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_code  = out_key_r;
  assign out_ch.pressed   = out_pressed_r;
  assign out_ch.modifiers = out_mods_r;

endmodule

`default_nettype wire

// File: dv/key_event_tb_pkg.sv
// ----------------------------------------------------------------------------
// key_event_tb_pkg
// Event tracking for the scan code translator bench: keeps its own copy of
// the keyboard flags and layout tables, predicts one event per scan byte and
// checks the events coming out of the block in order.
// ----------------------------------------------------------------------------
package key_event_tb_pkg;

  import kst_pkg::*;

  // keypad scan codes, navigation keys when prefixed, or when num lock is off and shift is not held
  localparam logic [6:0] SC_KP_HOME  = 7'h47;
  localparam logic [6:0] SC_KP_UP    = 7'h48;
  localparam logic [6:0] SC_KP_PGUP  = 7'h49;
  localparam logic [6:0] SC_KP_LEFT  = 7'h4B;
  localparam logic [6:0] SC_KP_RIGHT = 7'h4D;
  localparam logic [6:0] SC_KP_END   = 7'h4F;
  localparam logic [6:0] SC_KP_DOWN  = 7'h50;
  localparam logic [6:0] SC_KP_PGDN  = 7'h51;
  localparam logic [6:0] SC_KP_INS   = 7'h52;
  localparam logic [6:0] SC_KP_DEL   = 7'h53;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            pressed;
    logic [ModW-1:0] mods;
  } scan_event_t;

  class key_event_checker;
    kst_state_t   flags;
    logic [7:0]   lower_tab [128];
    logic [7:0]   upper_tab [128];
    scan_event_t  pending_events [$];
    int unsigned  bytes_seen;
    int unsigned  events_checked;
    int unsigned  keys_seen;
    int unsigned  mismatches;

    function new();
      flags = '0;
      bytes_seen = 0;
      events_checked = 0;
      keys_seen = 0;
      mismatches = 0;
      for (int i = 0; i < 128; i++) begin
        lower_tab[i] = 8'd0;
        upper_tab[i] = 8'd0;
      end
      // number row
      map_key('h01, 8'd27, 8'd27); map_key('h02, "1", "!");  map_key('h03, "2", 8'd39);
      map_key('h04, "3", "^");     map_key('h05, "4", "+");  map_key('h06, "5", "%");
      map_key('h07, "6", "&");     map_key('h08, "7", "/");  map_key('h09, "8", "(");
      map_key('h0A, "9", ")");     map_key('h0B, "0", "=");  map_key('h0C, "*", 8'd63);
      map_key('h0D, "-", "_");     map_key('h0E, 8'd8, 8'd8); map_key('h0F, 8'd9, 8'd9);
      // upper letter row
      map_key('h10, "q", "Q");     map_key('h11, "w", "W");  map_key('h12, "e", "E");
      map_key('h13, "r", "R");     map_key('h14, "t", "T");  map_key('h15, "y", "Y");
      map_key('h16, "u", "U");     map_key('h17, 8'd133, "I"); map_key('h18, "o", "O");
      map_key('h19, "p", "P");     map_key('h1A, 8'd129, 8'd139);
      map_key('h1B, 8'd132, 8'd137); map_key('h1C, 8'd10, 8'd10);
      // home row
      map_key('h1E, "a", "A");     map_key('h1F, "s", "S");  map_key('h20, "d", "D");
      map_key('h21, "f", "F");     map_key('h22, "g", "G");  map_key('h23, "h", "H");
      map_key('h24, "j", "J");     map_key('h25, "k", "K");  map_key('h26, "l", "L");
      map_key('h27, 8'd130, 8'd136); map_key('h28, "i", 8'd134);
      map_key('h29, 8'd34, "E");   map_key('h2B, ",", ";");  map_key('h56, "<", ">");
      // bottom row
      map_key('h2C, "z", "Z");     map_key('h2D, "x", "X");  map_key('h2E, "c", "C");
      map_key('h2F, "v", "V");     map_key('h30, "b", "B");  map_key('h31, "n", "N");
      map_key('h32, "m", "M");     map_key('h33, 8'd131, 8'd138);
      map_key('h34, 8'd128, 8'd135); map_key('h35, ".", ":"); map_key('h39, " ", " ");
    endfunction

    function void map_key(int unsigned c, logic [7:0] lo, logic [7:0] up);
      lower_tab[c] = lo;
      upper_tab[c] = up;
    endfunction

    function logic [KeyW-1:0] nav_key(logic [6:0] c);
      case (c)
        SC_KP_UP:    return NAV_UP;
        SC_KP_DOWN:  return NAV_DOWN;
        SC_KP_LEFT:  return NAV_LEFT;
        SC_KP_RIGHT: return NAV_RIGHT;
        SC_KP_HOME:  return NAV_HOME;
        SC_KP_END:   return NAV_END;
        SC_KP_PGUP:  return NAV_PAGEUP;
        SC_KP_PGDN:  return NAV_PAGEDN;
        SC_KP_INS:   return NAV_INS;
        SC_KP_DEL:   return NAV_DEL;
        default:     return KEY_NONE;
      endcase
    endfunction

    function logic [7:0] keypad_digit(logic [6:0] c);
      case (c)
        SC_KP_UP:    return "8";
        SC_KP_DOWN:  return "2";
        SC_KP_LEFT:  return "4";
        SC_KP_RIGHT: return "6";
        SC_KP_HOME:  return "7";
        SC_KP_END:   return "1";
        SC_KP_PGUP:  return "9";
        SC_KP_PGDN:  return "3";
        SC_KP_INS:   return "0";
        default:     return ".";
      endcase
    endfunction

    // key code of one scan byte; updates the held flags on the way
    function logic [KeyW-1:0] translate_scan(logic [7:0] sc);
      logic [6:0]      c;
      logic            rel;
      logic [KeyW-1:0] nav;
      logic [7:0]      lo;
      logic [7:0]      ch;
      logic            letter;
      logic            upper;
      c = sc[6:0];
      rel = sc[7];
      if (sc == SC_PREFIX_E0) begin
        flags.ext = 1'b1;
        return KEY_NONE;
      end
      if (c == SC_LSHIFT || c == SC_RSHIFT) begin
        flags.shift = !rel;
        return KEY_NONE;
      end
      if (c == SC_CTRL) begin
        flags.ctrl = !rel;
        return KEY_NONE;
      end
      if (c == SC_ALT) begin
        flags.alt = !rel;
        return KEY_NONE;
      end
      // lock keys toggle on make only; a release falls through as unmapped
      if (!rel && c == SC_CAPS) begin
        flags.caps = !flags.caps;
        return KEY_NONE;
      end
      if (!rel && c == SC_NUM) begin
        flags.num = !flags.num;
        return KEY_NONE;
      end

      nav = nav_key(c);
      if (flags.ext) begin
        flags.ext = 1'b0;
        if (nav != KEY_NONE) return nav;
        if (c == SC_ENTER) return {1'b0, CH_NEWLINE};
        if (c == SC_SLASH) return {1'b0, CH_SLASH};
      end
      if (nav != KEY_NONE)
        return (!flags.num && !flags.shift) ? nav : {1'b0, keypad_digit(c)};

      if (c >= SC_F1 && c <= SC_F10) return KEY_F1 + 9'(c - SC_F1);
      if (c == SC_F11) return KEY_F11;
      if (c == SC_F12) return KEY_F12;

      // character table, caps lock only flips letters
      lo = lower_tab[c];
      letter = (lo >= CH_LOWER_A && lo <= CH_LOWER_Z) || (lo >= 8'd128 && lo <= 8'd133);
      upper = flags.shift ^ (flags.caps & letter);
      ch = upper ? upper_tab[c] : lo;
      if (flags.ctrl && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        return {1'b0, ch - CH_LOWER_A + 8'd1};
      return {1'b0, ch};
    endfunction

    // accepted scan byte: queue the event it should cause
    function void note_byte(logic [7:0] sc);
      scan_event_t ev;
      ev.mods = {flags.alt, flags.ctrl, flags.shift};
      ev.pressed = !sc[7];
      ev.key = translate_scan(sc);
      pending_events.push_back(ev);
      bytes_seen++;
    endfunction

    // accepted event: compare with the oldest pending one
    function void check_event(logic [KeyW-1:0] key, logic pressed, logic [ModW-1:0] mods);
      scan_event_t want;
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: event with none pending: key %0d pressed %b mods %b",
                 $time, key, pressed, mods);
        return;
      end
      want = pending_events.pop_front();
      events_checked++;
      if (want.key != KEY_NONE) keys_seen++;
      if (key !== want.key) begin
        mismatches++;
        $display("%0t: key_code expected %0d actual %0d", $time, want.key, key);
      end
      if (pressed !== want.pressed) begin
        mismatches++;
        $display("%0t: pressed expected %b actual %b", $time, want.pressed, pressed);
      end
      if (mods !== want.mods) begin
        mismatches++;
        $display("%0t: modifiers expected %b actual %b", $time, want.mods, mods);
      end
    endfunction

    function int unsigned outstanding();
      return pending_events.size();
    endfunction
  endclass

endpackage

// File: dv/keyboard_scancode_translator_top_test.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_translator_top_test
// Drives scan bytes into the translator with random gaps and receiver stalls:
// a short directed opening, then random key sequences (typing, modifier
// chords, prefixed keys, lock toggles, keypad, broken prefixes and noise).
// Every event is checked against a predicted event in arrival order.
// ----------------------------------------------------------------------------
module keyboard_scancode_translator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kst_pkg::*;
  import key_event_tb_pkg::*;

  localparam int unsigned RANDOM_BYTES  = 900;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned OPENING_LEN   = 29;

  // directed opening: extremes, every modifier and lock, prefix corner cases
  localparam logic [7:0] OPENING [OPENING_LEN] = '{
    8'h00, 8'hFF, SC_PREFIX_E0, {1'b0, SC_KP_UP},
    {1'b0, SC_LSHIFT}, 8'h1E, {1'b1, SC_LSHIFT},
    {1'b0, SC_CAPS}, {1'b1, SC_CAPS}, 8'h17,
    {1'b0, SC_CTRL}, 8'h2C, {1'b1, SC_CTRL},
    {1'b0, SC_ALT}, {1'b0, SC_F1}, {1'b1, SC_ALT}, {1'b1, SC_F12},
    {1'b0, SC_NUM}, {1'b0, SC_KP_DEL}, {1'b1, SC_NUM},
    SC_PREFIX_E0, {1'b0, SC_RSHIFT}, {1'b0, SC_KP_HOME}, {1'b1, SC_RSHIFT},
    SC_PREFIX_E0, {1'b1, SC_SLASH}, SC_PREFIX_E0, 8'h10, {1'b0, SC_F11}
  };

  localparam logic [6:0] KEYPAD_CODES [10] = '{
    SC_KP_HOME, SC_KP_UP, SC_KP_PGUP, SC_KP_LEFT, SC_KP_RIGHT,
    SC_KP_END, SC_KP_DOWN, SC_KP_PGDN, SC_KP_INS, SC_KP_DEL
  };

  localparam logic [6:0] MODIFIER_CODES [4] = '{SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_ALT};

  logic clk = 1'b0;
  logic rst_n;

  kst_in_if  in_ch();
  kst_out_if out_ch();

  keyboard_scancode_translator_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_event_checker events_sb = new();
  int unsigned src_idle_pct  = 30;
  int unsigned sink_idle_pct = 30;
  int unsigned cycle_count   = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("keyboard_scancode_translator_top_test failed");
      $finish;
    end
  end

  // event receiver with random stalls
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = ($urandom_range(99) < sink_idle_pct) ? $urandom_range(1, 18) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      events_sb.check_event(out_ch.key_code, out_ch.pressed, out_ch.modifiers);
    end
  end

  // one scan byte beat, then a random gap
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.scan_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    events_sb.note_byte(b);
    gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 18) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every pending event has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (events_sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(3))
      1:       return 25;
      2:       return 60;
      default: return 0;
    endcase
  endfunction

  // one random key sequence
  task automatic send_sequence();
    int unsigned kind;
    logic [6:0]  c;
    logic [6:0]  m;
    kind = $urandom_range(99);
    if (kind < 12) begin
      send_byte(8'($urandom_range(255)));
    end else if (kind < 32) begin
      // plain typing
      c = 7'($urandom_range(1, 'h58));
      send_byte({1'b0, c});
      send_byte({1'b1, c});
    end else if (kind < 47) begin
      // modifier chord
      m = MODIFIER_CODES[$urandom_range(3)];
      send_byte({1'b0, m});
      repeat ($urandom_range(1, 3)) begin
        c = 7'($urandom_range(1, 'h58));
        send_byte({1'b0, c});
        send_byte({1'b1, c});
      end
      send_byte({1'b1, m});
    end else if (kind < 62) begin
      // prefixed key, sometimes with a modifier between prefix and key
      case ($urandom_range(4))
        0:       c = SC_ENTER;
        1:       c = SC_SLASH;
        2:       c = 7'($urandom_range(127));
        default: c = KEYPAD_CODES[$urandom_range(9)];
      endcase
      send_byte(SC_PREFIX_E0);
      if ($urandom_range(4) == 0) send_byte({1'b0, MODIFIER_CODES[$urandom_range(3)]});
      send_byte({1'b0, c});
      send_byte(SC_PREFIX_E0);
      send_byte({1'b1, c});
    end else if (kind < 72) begin
      // lock toggle
      c = $urandom_range(1) ? SC_CAPS : SC_NUM;
      send_byte({1'b0, c});
      send_byte({1'b1, c});
    end else if (kind < 87) begin
      // keypad key, meaning follows num lock and shift
      c = KEYPAD_CODES[$urandom_range(9)];
      send_byte({1'b0, c});
      send_byte({1'b1, c});
    end else if ($urandom_range(1) != 0) begin
      // prefix followed by anything
      send_byte(SC_PREFIX_E0);
      send_byte(8'($urandom_range(255)));
    end else begin
      // lone release
      send_byte({1'b1, 7'($urandom_range(127))});
    end
  endtask

  // stimulus
  initial begin
    int unsigned target;
    int unsigned next_mode_at;
    bit          paused;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.scan_byte <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING[i]) send_byte(OPENING[i]);
    wait_drained();

    target = events_sb.bytes_seen + RANDOM_BYTES;
    next_mode_at = events_sb.bytes_seen;
    paused = 1'b0;
    while (events_sb.bytes_seen < target) begin
      if (events_sb.bytes_seen >= next_mode_at) begin
        src_idle_pct  = pick_idle_pct();
        sink_idle_pct = pick_idle_pct();
        next_mode_at  = events_sb.bytes_seen + 100;
      end
      if (!paused && events_sb.bytes_seen >= target - RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_sequence();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d scan bytes, %0d events checked, %0d carrying a key code",
             events_sb.bytes_seen, events_sb.events_checked, events_sb.keys_seen);
    $display("typing, modifier chords, prefixed keys, lock toggles, keypad and noise");
    if (events_sb.mismatches == 0 && events_sb.outstanding() == 0)
      $display("keyboard_scancode_translator_top_test passed");
    else
      $display("keyboard_scancode_translator_top_test failed");
    $finish;
  end

endmodule

// File: sim.f
design/kst_pkg.sv
design/kst_if.sv
design/kst_decode.sv
design/keyboard_scancode_translator_top.sv
dv/key_event_tb_pkg.sv
dv/keyboard_scancode_translator_top_test.sv
